// ----- sv/rolling_string_hash_bucket_core_assert.svh -----
`ifndef ROLLING_STRING_HASH_BUCKET_CORE_ASSERT_SVH
`define ROLLING_STRING_HASH_BUCKET_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define RSHB_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define RSHB_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- sv/rshb_pkg.sv -----
package rshb_pkg;

    localparam int CHAR_W   = 7;
    localparam int HASH_W   = 30;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = 32;
    localparam int BUCKET_W = 13;

    localparam logic [SUM_W-1:0] HASH_MOD    = 32'd1000000009;
    localparam logic [SUM_W-1:0] HASH_MOD_X2 = 32'd2000000018;
    localparam logic [SUM_W-1:0] HASH_MOD_X3 = 32'd3000000027;
    localparam logic [SUM_W-1:0] HASH_MOD_X4 = 32'd4000000036;
    localparam logic [4:0]       HASH_BASE   = 5'd31;
    localparam logic [LEN_W-1:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  length;
        logic              key_end;
    } t_str_info;

    // A 32-bit value is below five times the modulus, so at most four
    // subtractions bring it into range.
    function automatic logic [HASH_W-1:0] hash_mod_reduce(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        if (v >= HASH_MOD_X4) begin
            r = v - HASH_MOD_X4;
        end else if (v >= HASH_MOD_X3) begin
            r = v - HASH_MOD_X3;
        end else if (v >= HASH_MOD_X2) begin
            r = v - HASH_MOD_X2;
        end else if (v >= HASH_MOD) begin
            r = v - HASH_MOD;
        end else begin
            r = v;
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

// ----- sv/rshb_stream_if.sv -----
interface rshb_in_if;
    import rshb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;
    logic              end_of_key;
    logic              empty_marker;

    modport source (
        output valid, char_code, end_of_string, end_of_key, empty_marker,
        input  ready
    );
    modport sink (
        input  valid, char_code, end_of_string, end_of_key, empty_marker,
        output ready
    );
endinterface

interface rshb_out_if;
    import rshb_pkg::*;

    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   string_hash;
    logic [LEN_W-1:0]    string_length;
    logic [BUCKET_W-1:0] bucket_index;
    logic                bucket_valid;

    modport source (
        output valid, string_hash, string_length, bucket_index, bucket_valid,
        input  ready
    );
    modport sink (
        input  valid, string_hash, string_length, bucket_index, bucket_valid,
        output ready
    );
endinterface

// ----- sv/rshb_bucket_mod.sv -----
module rshb_bucket_mod #(
    parameter int unsigned NUM_BUCKETS = 4098
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rshb_pkg::SUM_W-1:0]    i_total,
    input  rshb_pkg::t_str_info           i_info,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rshb_pkg::t_str_info           o_info,
    output logic [rshb_pkg::BUCKET_W-1:0] o_bucket
);
    import rshb_pkg::*;
    `include "rolling_string_hash_bucket_core_assert.svh"

    localparam int REM_W = $clog2(NUM_BUCKETS);
    localparam int N_W   = REM_W + 1;
    localparam int EXT_W = (REM_W > BUCKET_W) ? REM_W : BUCKET_W;
    localparam int QN_W  = SUM_W + N_W;
    localparam logic [N_W-1:0]   N_C      = N_W'(NUM_BUCKETS);
    localparam logic [63:0]      RECIP_64 = (64'd1 << 32) / 64'(NUM_BUCKETS);
    localparam logic [SUM_W-1:0] RECIP    = RECIP_64[SUM_W-1:0];
    localparam logic [SUM_W:0]   TWO_N    = 33'(2 * NUM_BUCKETS);

    logic             r1_v, r2_v, r3_v, r4_v;
    logic             w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic [SUM_W-1:0] r1_total, r2_total, r3_total;
    logic [SUM_W-1:0] r2_q, r3_qn;
    t_str_info        r1_info, r2_info, r3_info, r4_info;
    logic [BUCKET_W-1:0] r4_bucket;

    logic [63:0]      w_prod;
    logic [QN_W-1:0]  w_qn_full;
    logic [SUM_W-1:0] w_diff32;
    logic [N_W-1:0]   w_diff;
    logic [N_W-1:0]   w_rem_n;
    logic [EXT_W-1:0] w_rem_ext;
    logic [BUCKET_W-1:0] w_bucket;

    assign w_rdy4  = !r4_v || i_ready;
    assign w_rdy3  = !r3_v || w_rdy4;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_ready = w_rdy1;

    // The quotient estimate is low by at most one, so the difference stays
    // below twice the bucket count and one conditional subtract finishes it.
    assign w_prod    = 64'(r1_total) * 64'(RECIP);
    assign w_qn_full = QN_W'(r2_q) * QN_W'(N_C);
    assign w_diff32  = r3_total - r3_qn;
    assign w_diff    = w_diff32[N_W-1:0];
    assign w_rem_n   = (w_diff >= N_C) ? (w_diff - N_C) : w_diff;
    assign w_rem_ext = EXT_W'(w_rem_n[REM_W-1:0]);
    assign w_bucket  = r3_info.key_end ? w_rem_ext[BUCKET_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r1_total <= i_total;
            r1_info  <= i_info;
        end
        if (w_rdy2 && r1_v) begin
            r2_q     <= w_prod[63:32];
            r2_total <= r1_total;
            r2_info  <= r1_info;
        end
        if (w_rdy3 && r2_v) begin
            r3_qn    <= w_qn_full[SUM_W-1:0];
            r3_total <= r2_total;
            r3_info  <= r2_info;
        end
        if (w_rdy4 && r3_v) begin
            r4_bucket <= w_bucket;
            r4_info   <= r3_info;
        end
    end

    assign o_valid  = r4_v;
    assign o_info   = r4_info;
    assign o_bucket = r4_bucket;

    `RSHB_ASSERT_IMPL(a_quot_bound, r2_v, r2_q <= (r2_total >> 1), "Quotient estimate too large.")
    `RSHB_ASSERT_IMPL(a_diff_bound, r3_v, {1'b0, w_diff32} < TWO_N, "Remainder needs more than one correction.")
    `RSHB_ASSERT_IMPL(a_no_key_zero, r4_v && !r4_info.key_end, r4_bucket == '0, "Bucket index set without key end.")

endmodule

// ----- sv/rolling_string_hash_bucket_core.sv -----
// Throughput: one character transaction per cycle while i_in.ready is high; the hash state
// updates in the accept cycle.
// The bucket modulo is a four-stage pipeline with per-stage ready, so results stall the input
// only when all four stages are full.
// Reset (i_rst_n low, synchronous) sets hash 0, power 1, length 0 and key sum 0, and empties
// the pipeline.
module rolling_string_hash_bucket_core #(
    parameter int unsigned NUM_BUCKETS = 4098
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rshb_in_if.sink     i_in,
    rshb_out_if.source  o_out
);
    import rshb_pkg::*;
    `include "rolling_string_hash_bucket_core_assert.svh"

    logic [HASH_W-1:0] r_hash, n_hash;
    logic [HASH_W-1:0] r_power, n_power;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_key_sum, n_key_sum;

    logic                  w_accept;
    logic                  w_bkt_ready;
    logic [CHAR_W+HASH_W-1:0] w_prod;
    logic [SUM_W-1:0]      w_sum;
    logic [HASH_W-1:0]     w_hash_char;
    logic [HASH_W+4:0]     w_pow_prod;
    logic [HASH_W-1:0]     w_pow_char;
    logic [LEN_W-1:0]      w_count_char;
    logic [HASH_W-1:0]     w_hash_now;
    logic [LEN_W-1:0]      w_count_now;
    logic [SUM_W-1:0]      w_total;
    t_str_info             w_info;
    t_str_info             w_out_info;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = w_bkt_ready;

    assign w_prod       = (CHAR_W+HASH_W)'(i_in.char_code) * (CHAR_W+HASH_W)'(r_power);
    assign w_sum        = SUM_W'(r_hash) + w_prod[SUM_W-1:0];
    assign w_hash_char  = hash_mod_reduce(w_sum);
    assign w_pow_prod   = (HASH_W+5)'(r_power) * (HASH_W+5)'(HASH_BASE);
    assign w_pow_char   = hash_mod_reduce(w_pow_prod[SUM_W-1:0]);
    assign w_count_char = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    assign w_hash_now  = i_in.empty_marker ? r_hash : w_hash_char;
    assign w_count_now = i_in.empty_marker ? r_count : w_count_char;
    assign w_total     = r_key_sum + SUM_W'(w_hash_now);

    assign w_info.hash    = w_hash_now;
    assign w_info.length  = w_count_now;
    assign w_info.key_end = i_in.end_of_key;

    always_comb begin
        n_hash    = r_hash;
        n_power   = r_power;
        n_count   = r_count;
        n_key_sum = r_key_sum;
        if (w_accept) begin
            if (!i_in.empty_marker) begin
                n_hash  = w_hash_char;
                n_power = w_pow_char;
                n_count = w_count_char;
            end
            if (i_in.end_of_string) begin
                n_hash    = '0;
                n_power   = HASH_W'(1);
                n_count   = '0;
                n_key_sum = i_in.end_of_key ? '0 : w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= '0;
            r_power   <= HASH_W'(1);
            r_count   <= '0;
            r_key_sum <= '0;
        end else begin
            r_hash    <= n_hash;
            r_power   <= n_power;
            r_count   <= n_count;
            r_key_sum <= n_key_sum;
        end
    end

    rshb_bucket_mod #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_bucket_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept && i_in.end_of_string),
        .o_ready  (w_bkt_ready),
        .i_total  (w_total),
        .i_info   (w_info),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_info   (w_out_info),
        .o_bucket (o_out.bucket_index)
    );

    assign o_out.string_hash   = w_out_info.hash;
    assign o_out.string_length = w_out_info.length;
    assign o_out.bucket_valid  = w_out_info.key_end;

    `RSHB_ASSERT_IMPL(a_hash_range, 1'b1, SUM_W'(r_hash) < HASH_MOD,
        "Running hash out of range.")
    `RSHB_ASSERT_IMPL(a_power_range, 1'b1, (r_power != '0) && (SUM_W'(r_power) < HASH_MOD),
        "Power out of range.")
    `RSHB_ASSERT_NEXT(a_string_clear, w_accept && i_in.end_of_string,
        (r_hash == '0) && (r_power == HASH_W'(1)) && (r_count == '0),
        "String state not cleared.")
    `RSHB_ASSERT_NEXT(a_key_clear, w_accept && i_in.end_of_string && i_in.end_of_key,
        r_key_sum == '0, "Key sum not cleared.")

endmodule

// ----- tb/tb_rolling_string_hash_bucket_core.sv -----
`timescale 1ns / 1ps

module tb_rolling_string_hash_bucket_core;
    import rshb_pkg::*;

    localparam int unsigned BUCKET_COUNT = 4098;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned STALL_LIMIT  = 2000;

    typedef struct {
        bit [CHAR_W-1:0] ch;
        bit              eos;
        bit              eok;
        bit              empty;
        bit              drain;
        bit              stall_out;
    } t_char_item;

    typedef struct {
        bit [HASH_W-1:0]   hash;
        bit [LEN_W-1:0]    length;
        bit [BUCKET_W-1:0] bucket;
        bit                bucket_valid;
    } t_hash_result;

    logic i_clk;
    logic i_rst_n;

    rshb_in_if  in_ch ();
    rshb_out_if out_ch ();

    rolling_string_hash_bucket_core #(
        .NUM_BUCKETS(BUCKET_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_item   pending[$];
    t_hash_result due_hashes[$];
    t_char_item   cur_item;

    bit [HASH_W-1:0] run_hash  = '0;
    bit [HASH_W-1:0] power_acc = HASH_W'(1);
    bit [LEN_W-1:0]  char_cnt  = '0;
    bit [SUM_W-1:0]  key_sum   = '0;

    bit          holding;
    bit          in_took;
    bit          calm_tail;
    bit          hold_req;
    bit          hold_used;
    int unsigned send_gap;
    int unsigned take_gap;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned mismatch_count;
    int unsigned counted_items;
    t_hash_result seen;
    t_hash_result want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.char_code     = '0;
        in_ch.end_of_string = 1'b0;
        in_ch.end_of_key    = 1'b0;
        in_ch.empty_marker  = 1'b0;
        out_ch.ready        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Applies one accepted transaction to the hash state and queues the result it causes.
    function automatic void roll_hash_item(input t_char_item it);
        bit [SUM_W-1:0] prod;
        bit [SUM_W-1:0] sum32;
        bit [SUM_W-1:0] pw32;
        bit [SUM_W-1:0] total;
        t_hash_result   r;
        if (!it.empty) begin
            prod      = {25'd0, it.ch} * {2'd0, power_acc};
            sum32     = {2'd0, run_hash} + prod;
            run_hash  = HASH_W'(sum32 % HASH_MOD);
            pw32      = {2'd0, power_acc} * 32'(HASH_BASE);
            power_acc = HASH_W'(pw32 % HASH_MOD);
            if (char_cnt != COUNT_MAX) begin
                char_cnt = char_cnt + 1'b1;
            end
        end
        if (it.eos) begin
            total          = key_sum + {2'd0, run_hash};
            r.hash         = run_hash;
            r.length       = char_cnt;
            r.bucket       = '0;
            r.bucket_valid = 1'b0;
            if (it.eok) begin
                r.bucket       = BUCKET_W'(total % BUCKET_COUNT);
                r.bucket_valid = 1'b1;
                key_sum        = '0;
            end else begin
                key_sum = total;
            end
            run_hash  = '0;
            power_acc = HASH_W'(1);
            char_cnt  = '0;
            due_hashes.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint exp);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, exp);
        mismatch_count++;
    endtask

    task automatic queue_char(input bit [CHAR_W-1:0] ch, input bit eos, input bit eok,
                              input bit empty);
        t_char_item it;
        it = '{ch: ch, eos: eos, eok: eok, empty: empty, drain: 1'b0, stall_out: 1'b0};
        pending.push_back(it);
        if (!empty || eos) begin
            counted_items++;
        end
    endtask

    task automatic queue_drain();
        t_char_item it;
        it = '{ch: '0, eos: 1'b0, eok: 1'b0, empty: 1'b1, drain: 1'b1, stall_out: 1'b0};
        pending.push_back(it);
    endtask

    task automatic queue_string(input int unsigned len, input bit key_end, input bit noisy);
        if (len == 0) begin
            queue_char(CHAR_W'($urandom), 1'b1, key_end, 1'b1);
        end else begin
            for (int unsigned n = 0; n < len; n++) begin
                if (noisy && $urandom_range(0, 7) == 0) begin
                    queue_char(CHAR_W'($urandom), 1'b0, 1'($urandom), 1'b1);
                end
                queue_char(CHAR_W'($urandom), n == len - 1, key_end && (n == len - 1), 1'b0);
            end
        end
    endtask

    initial begin
        int unsigned n_strings;
        int unsigned pick;

        queue_char(7'd0, 1'b1, 1'b0, 1'b1);
        queue_char(7'd127, 1'b0, 1'b0, 1'b1);
        queue_char(7'd0, 1'b1, 1'b0, 1'b0);
        queue_char(7'd127, 1'b0, 1'b0, 1'b0);
        queue_char(7'd127, 1'b0, 1'b1, 1'b0);
        queue_char(7'd127, 1'b1, 1'b0, 1'b0);
        queue_char(7'd0, 1'b0, 1'b0, 1'b0);
        queue_char(7'd85, 1'b0, 1'b0, 1'b0);
        queue_char(7'd42, 1'b1, 1'b1, 1'b0);
        queue_char(7'd99, 1'b1, 1'b1, 1'b1);
        queue_char(7'd127, 1'b0, 1'b0, 1'b0);
        queue_char(7'd64, 1'b0, 1'b1, 1'b1);
        queue_char(7'd1, 1'b1, 1'b1, 1'b1);
        queue_drain();

        // Short strings behind a long output hold-off, so the core backs up into its input.
        for (int unsigned n = 0; n < 24; n++) begin
            queue_char(CHAR_W'($urandom), 1'b1, n % 4 == 3, 1'b0);
            if (n == 0) begin
                pending[$].stall_out = 1'b1;
            end
        end
        queue_drain();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                for (int unsigned s = 0; s < 4; s++) begin
                    queue_string($urandom_range(0, 10), s == 3, 1'b1);
                end
            end else if (pick < 16) begin
                n_strings = $urandom_range(1, 6);
                for (int unsigned s = 0; s < n_strings; s++) begin
                    queue_string($urandom_range(0, 6), 1'($urandom), 1'b0);
                end
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 5)) begin
                    queue_char(CHAR_W'($urandom), 1'b0, 1'($urandom), 1'($urandom));
                end
            end else begin
                queue_drain();
            end
        end

        while (pending.size() != 0 || holding) begin
            @(posedge i_clk);
        end
        while (due_hashes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid = 1'b0;
        end else begin
            if (in_took) begin
                holding = 1'b0;
                in_took = 1'b0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending.size() != 0) begin
                    if (pending[0].drain) begin
                        if (due_hashes.size() == 0) begin
                            void'(pending.pop_front());
                        end
                    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 5);
                    end else begin
                        cur_item = pending.pop_front();
                        holding  = 1'b1;
                    end
                end
            end
            in_ch.valid         = holding;
            in_ch.char_code     = cur_item.ch;
            in_ch.end_of_string = cur_item.eos;
            in_ch.end_of_key    = cur_item.eok;
            in_ch.empty_marker  = cur_item.empty;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
        end else begin
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                out_ch.ready = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                take_gap     = $urandom_range(0, 5);
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            calm_tail = pending.size() < CALM_TAIL;
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                roll_hash_item('{ch: in_ch.char_code, eos: in_ch.end_of_string,
                                 eok: in_ch.end_of_key, empty: in_ch.empty_marker,
                                 drain: 1'b0, stall_out: 1'b0});
                if (cur_item.stall_out) begin
                    hold_req = 1'b1;
                end
                in_took = 1'b1;
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                seen.hash         = out_ch.string_hash;
                seen.length       = out_ch.string_length;
                seen.bucket       = out_ch.bucket_index;
                seen.bucket_valid = out_ch.bucket_valid;
                if (due_hashes.size() == 0) begin
                    report_mismatch("unexpected transaction, hash", seen.hash, 0);
                end else begin
                    want = due_hashes.pop_front();
                    if (out_ch.string_hash !== want.hash) begin
                        report_mismatch("string_hash", seen.hash, want.hash);
                    end
                    if (out_ch.string_length !== want.length) begin
                        report_mismatch("string_length", seen.length, want.length);
                    end
                    if (out_ch.bucket_index !== want.bucket) begin
                        report_mismatch("bucket_index", seen.bucket, want.bucket);
                    end
                    if (out_ch.bucket_valid !== want.bucket_valid) begin
                        report_mismatch("bucket_valid", seen.bucket_valid, want.bucket_valid);
                    end
                end
            end
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                    || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("timeout after %0d cycles without a transaction", idle_cycles);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rshb_pkg.sv
sv/rshb_stream_if.sv
sv/rshb_bucket_mod.sv
sv/rolling_string_hash_bucket_core.sv
tb/tb_rolling_string_hash_bucket_core.sv
